// ----- sv/tpac_pkg.sv -----
// Package: shared constants, register indexes and pipeline types of the compositor.
package tpac_pkg;

   localparam int LANES       = 3;
   localparam int DIV_STEPS   = 16;
   localparam int CSR_ADDR_W  = 4;
   localparam int RECIP_SHIFT = 23;

   localparam logic [15:0] ONE_FIXED = 16'hFF00;
   localparam logic [7:0]  FULL8     = 8'hFF;
   localparam logic [15:0] RECIP255  = 16'h8081;

   localparam logic [1:0] REG_FG   = 2'd0;
   localparam logic [1:0] REG_BG   = 2'd1;
   localparam logic [1:0] REG_MODE = 2'd2;

   localparam logic MODE_COVER   = 1'b0;
   localparam logic MODE_UNPREMUL = 1'b1;

   typedef logic [LANES-1:0][23:0] num_type;
   typedef logic [LANES-1:0][15:0] quo_type;

   typedef struct packed {
      logic        byp;
      logic [31:0] pix;
      logic [7:0]  alpha;
   } side_type;

   typedef struct packed {
      logic        mode;
      logic [15:0] p;
      logic [15:0] src;
      logic [23:0] y;
      logic [15:0] dst;
      num_type     num;
      logic [15:0] den;
      side_type    side;
   } op_type;

   typedef struct packed {
      num_type     num;
      logic [15:0] den;
      side_type    side;
   } div_op_type;

endpackage

// ----- sv/tpac_if.sv -----
// Interfaces: pixel input channel and RGBA result channel.
interface tpac_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] raw_pixel;
   modport source (output valid, output raw_pixel, input ready);
   modport sink (input valid, input raw_pixel, output ready);
endinterface

interface tpac_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic [7:0] out_alpha;
   modport source (output valid, output out_red, output out_green, output out_blue,
                   output out_alpha, input ready);
   modport sink (input valid, input out_red, input out_green, input out_blue,
                 input out_alpha, output ready);
endinterface

// ----- sv/text_pixel_alpha_compositor.sv -----
// Top level: text pixel alpha compositor with APB register port.
//
// Usage: pixels enter on req_chan (raw_pixel), one item per cycle, and leave
// on rsp_chan as straight-alpha RGBA8. render_mode 0 lays fg_color over
// bg_color weighted by the coverage byte; render_mode 1 turns a premultiplied
// BGRA pixel back into straight RGBA. Registers fg_color (0x0), bg_color
// (0x4) and render_mode (0x8) are written over APB, by the user only while no
// item is in flight (not enforced by the block); reads return the stored value.
// Pipeline: 6 front stages for the alpha arithmetic, then 16 divider stages,
// one quotient bit each; rsp valid is taken from the last divider stage.
// Throughput: one item per cycle, sustained while rsp_chan is not stalled.
// Reset: empties the pipeline and clears the APB registers (transparent black,
// coverage mode).
// Stall: when rsp is valid but not ready, the whole pipeline holds and
// req_chan.ready drops in the same cycle; nothing is lost or repeated.
// Bubbles flow through with their valid bits cleared.
module text_pixel_alpha_compositor
   import tpac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   tpac_req_if.sink              req_chan,
   tpac_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [31:0] fg_ff, bg_ff;
   logic        mode_ff;
   logic        wr_en;
   logic        en;
   logic        front_valid;
   div_op_type  front_op;
   side_type    fin_side;
   quo_type     fin_quo;

   // config write at the access phase
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff   <= '0;
         bg_ff   <= '0;
         mode_ff <= MODE_COVER;
      end else if (wr_en) begin
         unique case (paddr[3:2])
            REG_FG:   fg_ff   <= pwdata;
            REG_BG:   bg_ff   <= pwdata;
            REG_MODE: mode_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_FG:   prdata = fg_ff;
         REG_BG:   prdata = bg_ff;
         REG_MODE: prdata = {31'b0, mode_ff};
         default:  prdata = '0;
      endcase
   end

   // advance everything unless the final result is held by the receiver
   assign en             = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = en;

   tpac_front u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_chan.valid),
      .raw_pixel   (req_chan.raw_pixel),
      .fg_color    (fg_ff),
      .bg_color    (bg_ff),
      .render_mode (mode_ff),
      .out_valid   (front_valid),
      .out_op      (front_op)
   );

   tpac_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_op     (front_op),
      .out_valid (rsp_chan.valid),
      .out_side  (fin_side),
      .out_quo   (fin_quo)
   );

   // pick pass-through pixel or quotient low bytes (unpremultiply wraps)
   always_comb begin
      if (fin_side.byp) begin
         rsp_chan.out_red   = fin_side.pix[7:0];
         rsp_chan.out_green = fin_side.pix[15:8];
         rsp_chan.out_blue  = fin_side.pix[23:16];
         rsp_chan.out_alpha = fin_side.pix[31:24];
      end else begin
         rsp_chan.out_red   = fin_quo[0][7:0];
         rsp_chan.out_green = fin_quo[1][7:0];
         rsp_chan.out_blue  = fin_quo[2][7:0];
         rsp_chan.out_alpha = fin_side.alpha;
      end
   end

endmodule

// ----- sv/tpac_front.sv -----
// Front pipeline: coverage alpha math and divider operand setup, six register stages.
module tpac_front
   import tpac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [31:0] raw_pixel,
   input  logic [31:0] fg_color,
   input  logic [31:0] bg_color,
   input  logic        render_mode,
   output logic        out_valid,
   output div_op_type  out_op
);

   logic [5:0]  v_ff;
   op_type      op_ff [6];
   op_type      c0, c1, c2, c3, c4, c5;
   logic [16:0] p17, t17, sum17;
   logic [15:0] diff;
   logic [39:0] prod40;
   logic [24:0] chk;

   // stage 0: capture, coverage product, unpremultiply numerators
   always_comb begin
      c0 = '0;
      c0.mode = render_mode;
      if (render_mode == MODE_UNPREMUL) begin
         for (int i = 0; i < LANES; i++) begin
            c0.num[i] = {8'b0, raw_pixel[8*(2-i) +: 8], 8'b0}
                        - {16'b0, raw_pixel[8*(2-i) +: 8]};
         end
         c0.den        = {8'b0, raw_pixel[31:24]};
         c0.side.byp   = (raw_pixel[31:24] == 8'd0);
         c0.side.pix   = {raw_pixel[31:24], raw_pixel[7:0], raw_pixel[15:8],
                          raw_pixel[23:16]};
         c0.side.alpha = raw_pixel[31:24];
      end else begin
         c0.p = {8'b0, fg_color[31:24]} * {8'b0, raw_pixel[7:0]};
         if (raw_pixel[7:0] == 8'd0) begin
            c0.side.byp = 1'b1;
            c0.side.pix = bg_color;
         end else if (raw_pixel[7:0] == FULL8 && fg_color[31:24] == FULL8) begin
            c0.side.byp = 1'b1;
            c0.side.pix = fg_color;
         end
      end
   end

   // stage 1: src = p*256/255 = p + p/255
   always_comb begin
      c1  = op_ff[0];
      p17 = {1'b0, op_ff[0].p};
      t17 = (p17 + 17'd1 + (p17 >> 8)) >> 8;
      c1.src = op_ff[0].p + t17[15:0];
   end

   // stage 2: y = bg.a * (one - src)
   always_comb begin
      c2   = op_ff[1];
      diff = ONE_FIXED - op_ff[1].src;
      c2.y = {16'b0, bg_color[31:24]} * {8'b0, diff};
   end

   // stage 3: estimate y/255 by reciprocal, may be one high
   always_comb begin
      c3     = op_ff[2];
      prod40 = {16'b0, op_ff[2].y} * {24'b0, RECIP255};
      c3.dst = prod40[RECIP_SHIFT +: 16];
   end

   // stage 4: correct the estimate
   always_comb begin
      c4  = op_ff[3];
      chk = {1'b0, op_ff[3].dst, 8'b0} - {9'b0, op_ff[3].dst};
      if (chk > {1'b0, op_ff[3].y}) begin
         c4.dst = op_ff[3].dst - 16'd1;
      end
   end

   // stage 5: output alpha and weighted color sums
   always_comb begin
      c5    = op_ff[4];
      sum17 = {1'b0, op_ff[4].src} + {1'b0, op_ff[4].dst};
      if (op_ff[4].mode == MODE_COVER && !op_ff[4].side.byp) begin
         c5.den        = sum17[15:0];
         c5.side.alpha = sum17[15:8];
         if (sum17 == 17'd0) begin
            c5.side.byp = 1'b1;
            c5.side.pix = '0;
         end
         for (int i = 0; i < LANES; i++) begin
            c5.num[i] = {16'b0, fg_color[8*i +: 8]} * {8'b0, op_ff[4].src}
                      + {16'b0, bg_color[8*i +: 8]} * {8'b0, op_ff[4].dst};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op_ff[0] <= c0;
         op_ff[1] <= c1;
         op_ff[2] <= c2;
         op_ff[3] <= c3;
         op_ff[4] <= c4;
         op_ff[5] <= c5;
      end
   end

   assign out_valid   = v_ff[5];
   assign out_op.num  = op_ff[5].num;
   assign out_op.den  = op_ff[5].den;
   assign out_op.side = op_ff[5].side;

endmodule

// ----- sv/tpac_divider.sv -----
// Divider: three-lane restoring divider, one quotient bit per register stage.
module tpac_divider
   import tpac_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  logic       in_valid,
   input  div_op_type in_op,
   output logic       out_valid,
   output side_type   out_side,
   output quo_type    out_quo
);

   typedef struct packed {
      num_type     num;
      logic [15:0] den;
      quo_type     rem;
      quo_type     quo;
      side_type    side;
   } dstage_type;

   function automatic dstage_type div_step(dstage_type s);
      dstage_type  r;
      logic [16:0] t;
      logic        bit_q;
      r = s;
      for (int i = 0; i < LANES; i++) begin
         t     = {s.rem[i], s.num[i][15]};
         bit_q = (t >= {1'b0, s.den});
         if (bit_q) begin
            t = t - {1'b0, s.den};
         end
         r.rem[i] = t[15:0];
         r.quo[i] = {s.quo[i][14:0], bit_q};
         r.num[i] = {s.num[i][22:0], 1'b0};
      end
      return r;
   endfunction

   logic [DIV_STEPS-1:0] v_ff;
   dstage_type           st_ff [DIV_STEPS];
   dstage_type           entry;

   // quotient fits 16 bits, so the top numerator byte is already below the divisor
   always_comb begin
      entry      = '0;
      entry.num  = in_op.num;
      entry.den  = in_op.den;
      entry.side = in_op.side;
      for (int i = 0; i < LANES; i++) begin
         entry.rem[i] = {8'b0, in_op.num[i][23:16]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[DIV_STEPS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= div_step(entry);
         for (int k = 1; k < DIV_STEPS; k++) begin
            st_ff[k] <= div_step(st_ff[k-1]);
         end
      end
   end

   assign out_valid = v_ff[DIV_STEPS-1];
   assign out_side  = st_ff[DIV_STEPS-1].side;
   assign out_quo   = st_ff[DIV_STEPS-1].quo;

endmodule

// ----- sv/tpac_checker.sv -----
// Checker: port-level assertions for the compositor, bound to the top level.
module tpac_props (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_alpha
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_ready_tracks_stall: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow output stall");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) && $stable(rsp_alpha))
      else $error("stalled result changed");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !(req_valid && req_ready))
      else $error("item accepted while output stalled");

endmodule

bind text_pixel_alpha_compositor tpac_props u_tpac_props (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_red   (rsp_chan.out_red),
   .rsp_alpha (rsp_chan.out_alpha)
);

// ----- dv/tpac_checker.sv -----
// Checker: watches both pixel channels, predicts each RGBA result and compares.
module tpac_checker
   import tpac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_pixel,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_rgba,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0] pwdata,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [31:0] fg_reg, bg_reg;
   logic        mode_reg;
   logic [31:0] rgba_queue[$];

   // Pack as {alpha, blue, green, red}.
   function automatic logic [31:0] composite(logic [31:0] px);
      logic [31:0] fr, fg, fb, fa, br, bg, bb, ba, r, g, b, a, cov;
      logic [31:0] src, dst, sum;
      fr = fg_reg[7:0]; fg = fg_reg[15:8]; fb = fg_reg[23:16]; fa = fg_reg[31:24];
      br = bg_reg[7:0]; bg = bg_reg[15:8]; bb = bg_reg[23:16]; ba = bg_reg[31:24];
      if (mode_reg == MODE_UNPREMUL) begin
         b = px[7:0]; g = px[15:8]; r = px[23:16]; a = px[31:24];
         if (a != 0) begin
            r = r * 255 / a; g = g * 255 / a; b = b * 255 / a;
         end
         return {a[7:0], b[7:0], g[7:0], r[7:0]};
      end
      cov = px[7:0];
      if (cov == 0) return bg_reg;
      if (cov == 255 && fa == 255) return fg_reg;
      src = fa * 256 * cov / 255;
      dst = ba * 256 * (32'hFF00 - src) / 32'hFF00;
      sum = src + dst;
      if (sum == 0) return 32'h0;
      r = (fr * src + br * dst) / sum;
      g = (fg * src + bg * dst) / sum;
      b = (fb * src + bb * dst) / sum;
      a = sum / 256;
      return {a[7:0], b[7:0], g[7:0], r[7:0]};
   endfunction

   assign pending = rgba_queue.size();

   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         fg_reg <= '0; bg_reg <= '0; mode_reg <= MODE_COVER;
         fail_count <= 0;
         rgba_queue.delete();
      end else begin
         if (psel && penable && pwrite && pready)
            case (paddr[3:2])
               REG_FG:   fg_reg <= pwdata;
               REG_BG:   bg_reg <= pwdata;
               REG_MODE: mode_reg <= pwdata[0];
               default: ;
            endcase
         if (req_valid && req_ready) rgba_queue.push_back(composite(req_pixel));
         if (rsp_valid && rsp_ready) begin
            if (rgba_queue.size() == 0) begin
               $display("%0t: unexpected item, actual %h", $time, rsp_rgba);
               fail_count <= fail_count + 1;
            end else begin
               want = rgba_queue.pop_front();
               if (want != rsp_rgba) begin
                  $display("%0t: mismatch expected %h actual %h (abgr)", $time, want,
                           rsp_rgba);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ----- dv/testbench.sv -----
// Testbench top: drives pixels and registers of the compositor and gives the verdict.
module testbench
   import tpac_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0, reset = 1'b1;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0, prdata;
   logic pready;
   int   fail_count, pending;
   bit   calm = 0;  // stretch with no idling on either side

   tpac_req_if req_chan ();
   tpac_rsp_if rsp_chan ();

   text_pixel_alpha_compositor dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   tpac_checker checker_u (
      .clock(clock), .reset(reset),
      .req_valid(req_chan.valid), .req_ready(req_chan.ready),
      .req_pixel(req_chan.raw_pixel),
      .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
      .rsp_rgba({rsp_chan.out_alpha, rsp_chan.out_blue, rsp_chan.out_green,
                 rsp_chan.out_red}),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.raw_pixel = '0;
      rsp_chan.ready = 1'b0;
   end

   // Receiver: stall at random with a chance of 9 in 100, never during the calm stretch.
   always @(posedge clock)
      rsp_chan.ready <= calm || ($urandom_range(99) >= 9);

   // Write one register: setup phase, then access phase.
   task automatic write_reg(logic [1:0] index, logic [31:0] value);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= {index, 2'b00}; pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
   endtask

   // Hand over one pixel item, idling at random before it.
   task automatic send_pixel(logic [31:0] px);
      if (!calm && $urandom_range(99) < 9) begin
         req_chan.valid <= 0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.raw_pixel <= px;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Drain the pipeline before touching registers.
   task automatic drain();
      req_chan.valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic set_all(logic [31:0] fgc, logic [31:0] bgc, logic mode);
      drain();
      write_reg(REG_FG, fgc);
      write_reg(REG_BG, bgc);
      write_reg(REG_MODE, {31'b0, mode});
   endtask

   // Coverage pixel with random upper bits, biased toward the fast-path values.
   function automatic logic [31:0] cover_pixel();
      logic [7:0] cov;
      case ($urandom_range(9))
         0: cov = 8'd0;
         1: cov = 8'hFF;
         default: cov = 8'($urandom);
      endcase
      return {24'($urandom_range(32'hFFFFFF)), cov};
   endfunction

   function automatic logic [31:0] rand_color();
      logic [31:0] c;
      c = $urandom;
      case ($urandom_range(5))
         0: c[31:24] = 8'hFF;
         1: c[31:24] = 8'h00;
         default: ;
      endcase
      return c;
   endfunction

   initial begin
      logic [31:0] px;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Reset values: transparent black, coverage mode.
      send_pixel(32'h0000_0080);
      send_pixel(32'hFFFF_FFFF);

      // Coverage extremes with opaque fg over half-transparent bg.
      set_all(32'hFF10_20F0, 32'h8033_CC01, MODE_COVER);
      send_pixel(32'h0000_0000);
      send_pixel(32'hFFFF_FF00);
      send_pixel(32'h0000_00FF);
      send_pixel(32'h0000_0001);
      send_pixel(32'h1234_5680);
      // Full coverage with non-opaque fg takes the blend path.
      set_all(32'h7FFF_00FF, 32'hFFFF_FFFF, MODE_COVER);
      send_pixel(32'h0000_00FF);
      send_pixel(32'h0000_0040);
      // Zero output alpha: transparent fg and bg.
      set_all(32'h00AB_CDEF, 32'h0012_3456, MODE_COVER);
      send_pixel(32'h0000_0077);
      send_pixel(32'h0000_00FF);

      // Unpremultiply: zero alpha, channel above alpha, full alpha.
      set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, MODE_UNPREMUL);
      send_pixel(32'h0000_0000);
      send_pixel(32'h00AB_CDEF);
      send_pixel(32'h01FF_FFFF);
      send_pixel(32'h40FF_8020);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'hFF00_0000);
      send_pixel(32'h8040_2010);

      // Random phases; each changes every register.
      for (int phase = 0; phase < 14; phase++) begin
         set_all(rand_color(), rand_color(), phase[0]);
         calm = (phase == 5);
         for (int n = 0; n < 100; n++) begin
            if (phase[0]) begin
               px = $urandom;
               if ($urandom_range(3) == 0) px[31:24] = 8'hFF;
               if ($urandom_range(7) == 0) px[31:24] = 8'h00;
            end else
               px = cover_pixel();
            send_pixel(px);
         end
         calm = 0;
      end

      drain();
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #2ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule

// ----- text_pixel_alpha_compositor.f -----
sv/tpac_pkg.sv
sv/tpac_if.sv
sv/tpac_front.sv
sv/tpac_divider.sv
sv/text_pixel_alpha_compositor.sv
sv/tpac_checker.sv
dv/tpac_checker.sv
dv/testbench.sv
